@@ hdl/vlc_pkg.sv @@
// Shared types and fixed-point widths for the vertex light colour pipeline.
`timescale 1ns / 1ps

package vlc_pkg;

   // Colour channels are unsigned Q2.8.
   localparam int CH_W        = 10;
   localparam int LIGHTS_MAX  = 6;
   localparam int INTEN_W     = 16;
   localparam int SCALE_W     = 16;
   localparam int CSR_W       = 60;

   // Positive part of intensity times scale, 25 fractional bits.
   localparam int PROD_W      = 31;
   // Light channel times clamped intensity, 33 fractional bits.
   localparam int LP_W        = PROD_W + CH_W;
   localparam int PS_W        = LP_W + 1;
   // Lit sum with 33 fractional bits, room for six lights plus ambient.
   localparam int ACC_W       = 45;
   localparam int AMB_SHIFT   = 25;
   // Sum times diffuse channel, 41 fractional bits.
   localparam int PRD_W       = ACC_W + CH_W;
   localparam int P_W         = 50;
   // Every channel value is brought to 49 fractional bits before conversion.
   localparam int V_W         = 60;
   localparam int FRAC_W      = 49;
   localparam int ONE_SHIFT   = 41;
   localparam int LIT_SHIFT   = 8;
   localparam int ALPHA_SHIFT = 33;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd4096;

   typedef enum logic [1:0] {
      MODE_MATERIAL   = 2'd0,
      MODE_VERTEX     = 2'd1,
      MODE_LIT        = 2'd2,
      MODE_LIT_VERTEX = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CFG_LIGHT_PAIR_A   = 3'd0,
      CFG_LIGHT_PAIR_B   = 3'd1,
      CFG_LIGHT_PAIR_C   = 3'd2,
      CFG_AMBIENT_RGB    = 3'd3,
      CFG_DIFFUSE_ARGB   = 3'd4,
      CFG_INTEN_SCALE    = 3'd5,
      CFG_LIGHT_ENABLE   = 3'd6
   } cfg_index_type;

   typedef logic [CH_W-1:0] chan_type;

   // Per-item data that rides alongside the lighting arithmetic.
   // Vertex channels: 0 blue, 1 green, 2 red, 3 alpha.
   typedef struct packed {
      mode_type          mode;
      logic [3:0][CH_W-1:0] vtx;
   } side_type;

endpackage

@@ hdl/vertex_light_color_top.sv @@
// Top level of the per-vertex diffuse lighting pipeline.
`timescale 1ns / 1ps

// Per-vertex diffuse lighting. Each item on the req_ channel yields exactly one
// packed 8-bit ARGB colour on the rsp_ channel, in order. The mode field picks
// the diffuse material, the vertex colour, the lit colour, or the lit colour
// times the vertex colour. The lit colour is the ambient material plus, for
// every enabled light, its colour times max(intensity * scale, 0), multiplied
// by the diffuse material; every channel is clamped to one and scaled by 255
// with truncation. The datapath is a seven-stage pipeline: intensity scaling,
// light colour products, pair sums, the final sum with ambient, the diffuse
// product, the vertex product, and the byte conversion in the output register.
// It accepts one item every clock unless the output stalls. Each stage has its
// own valid bit and moves when the stage after it is empty or moving, so
// bubbles are squeezed out while the output waits and an item is still taken
// while a finished result sits in the output register. The csr_ registers
// are read live by stages one, two, four, five and six, so they must only
// be written while no item is in flight.
module vertex_light_color_top
   import vlc_pkg::*;
#(
   parameter int LIGHT_COUNT = 6
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [CSR_W-1:0]    csr_wdata,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_mode,
   input  logic [CH_W-1:0]     req_vertex_alpha,
   input  logic [CH_W-1:0]     req_vertex_red,
   input  logic [CH_W-1:0]     req_vertex_green,
   input  logic [CH_W-1:0]     req_vertex_blue,
   input  logic signed [INTEN_W-1:0] req_intensity_zero,
   input  logic signed [INTEN_W-1:0] req_intensity_one,
   input  logic signed [INTEN_W-1:0] req_intensity_two,
   input  logic signed [INTEN_W-1:0] req_intensity_three,
   input  logic signed [INTEN_W-1:0] req_intensity_four,
   input  logic signed [INTEN_W-1:0] req_intensity_five,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [31:0]         rsp_packed_color
);

   localparam int STAGES = 7;
   localparam int NPAIR  = (LIGHT_COUNT + 1) / 2;

   // ------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------
   logic [CSR_W-1:0]       pair_a_ff, pair_b_ff, pair_c_ff;
   logic [3*CH_W-1:0]      ambient_ff;
   logic [4*CH_W-1:0]      diffuse_ff;
   logic [SCALE_W-1:0]     scale_ff;
   logic [LIGHTS_MAX-1:0]  enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_a_ff  <= '0;
         pair_b_ff  <= '0;
         pair_c_ff  <= '0;
         ambient_ff <= '0;
         diffuse_ff <= '0;
         scale_ff   <= SCALE_RESET;
         enable_ff  <= '0;
      end else if (csr_we) begin
         case (cfg_index_type'(csr_index))
            CFG_LIGHT_PAIR_A: begin
               pair_a_ff <= csr_wdata;
            end
            CFG_LIGHT_PAIR_B: begin
               pair_b_ff <= csr_wdata;
            end
            CFG_LIGHT_PAIR_C: begin
               pair_c_ff <= csr_wdata;
            end
            CFG_AMBIENT_RGB: begin
               ambient_ff <= csr_wdata[3*CH_W-1:0];
            end
            CFG_DIFFUSE_ARGB: begin
               diffuse_ff <= csr_wdata[4*CH_W-1:0];
            end
            CFG_INTEN_SCALE: begin
               scale_ff <= csr_wdata[SCALE_W-1:0];
            end
            CFG_LIGHT_ENABLE: begin
               enable_ff <= csr_wdata[LIGHTS_MAX-1:0];
            end
            default: begin
               // Writes beyond the last register are dropped.
            end
         endcase
      end
   end

   // Light colours: even lights sit in the low half of a pair register.
   logic [3*CH_W-1:0] light_rgb [LIGHTS_MAX];
   assign light_rgb[0] = pair_a_ff[3*CH_W-1:0];
   assign light_rgb[1] = pair_a_ff[6*CH_W-1:3*CH_W];
   assign light_rgb[2] = pair_b_ff[3*CH_W-1:0];
   assign light_rgb[3] = pair_b_ff[6*CH_W-1:3*CH_W];
   assign light_rgb[4] = pair_c_ff[3*CH_W-1:0];
   assign light_rgb[5] = pair_c_ff[6*CH_W-1:3*CH_W];

   logic signed [INTEN_W-1:0] inten [LIGHTS_MAX];
   assign inten[0] = req_intensity_zero;
   assign inten[1] = req_intensity_one;
   assign inten[2] = req_intensity_two;
   assign inten[3] = req_intensity_three;
   assign inten[4] = req_intensity_four;
   assign inten[5] = req_intensity_five;

   // ------------------------------------------------------------------
   // Pipeline control. A stage may load when it is empty or when the
   // stage after it is loading in the same cycle.
   // ------------------------------------------------------------------
   logic [STAGES:1] vld_ff, vld_in, rdy;

   always_comb begin
      rdy[STAGES] = !vld_ff[STAGES] || rsp_ready;
      for (int k = STAGES - 1; k >= 1; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_in[1] = rdy[1] ? req_valid : vld_ff[1];
      for (int k = 2; k <= STAGES; k++) begin
         vld_in[k] = rdy[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = rdy[1];
   assign rsp_valid = vld_ff[STAGES];

   // Mode and vertex colour travel down stages one to six.
   side_type side_in;
   side_type side_ff [1:STAGES-1];

   assign side_in.mode   = mode_type'(req_mode);
   assign side_in.vtx[0] = req_vertex_blue;
   assign side_in.vtx[1] = req_vertex_green;
   assign side_in.vtx[2] = req_vertex_red;
   assign side_in.vtx[3] = req_vertex_alpha;

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         side_ff[1] <= side_in;
      end
      for (int k = 2; k <= STAGES - 1; k++) begin
         if (rdy[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: scaled intensity, with negative or disabled lights at zero.
   // ------------------------------------------------------------------
   logic signed [2*INTEN_W:0] prod_full [LIGHT_COUNT];
   logic [PROD_W-1:0]         s1_prod_in [LIGHT_COUNT];
   logic [PROD_W-1:0]         s1_prod_ff [LIGHT_COUNT];

   always_comb begin
      for (int i = 0; i < LIGHT_COUNT; i++) begin
         prod_full[i]  = inten[i] * $signed({1'b0, scale_ff});
         s1_prod_in[i] = (enable_ff[i] && prod_full[i] > 0) ?
                         prod_full[i][PROD_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s1_prod_ff <= s1_prod_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: light colour channel times scaled intensity.
   // ------------------------------------------------------------------
   logic [LP_W-1:0] s2_lp_in [LIGHT_COUNT][3];
   logic [LP_W-1:0] s2_lp_ff [LIGHT_COUNT][3];

   always_comb begin
      for (int i = 0; i < LIGHT_COUNT; i++) begin
         for (int c = 0; c < 3; c++) begin
            s2_lp_in[i][c] = LP_W'(light_rgb[i][c*CH_W +: CH_W]) * LP_W'(s1_prod_ff[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         s2_lp_ff <= s2_lp_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: lights summed in pairs; an odd last light passes alone.
   // ------------------------------------------------------------------
   logic [PS_W-1:0] s3_ps_in [NPAIR][3];
   logic [PS_W-1:0] s3_ps_ff [NPAIR][3];

   for (genvar j = 0; j < NPAIR; j++) begin : g_pair
      for (genvar c = 0; c < 3; c++) begin : g_chan
         if (2 * j + 1 < LIGHT_COUNT) begin : g_two
            assign s3_ps_in[j][c] = PS_W'(s2_lp_ff[2*j][c]) + PS_W'(s2_lp_ff[2*j+1][c]);
         end else begin : g_one
            assign s3_ps_in[j][c] = PS_W'(s2_lp_ff[2*j][c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         s3_ps_ff <= s3_ps_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: ambient plus the pair sums, 33 fractional bits.
   // ------------------------------------------------------------------
   logic [ACC_W-1:0] s4_acc_in [3];
   logic [ACC_W-1:0] s4_acc_ff [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         s4_acc_in[c] = ACC_W'({ambient_ff[c*CH_W +: CH_W], AMB_SHIFT'(0)});
         for (int j = 0; j < NPAIR; j++) begin
            s4_acc_in[c] = s4_acc_in[c] + ACC_W'(s3_ps_ff[j][c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         s4_acc_ff <= s4_acc_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: times the diffuse channel. Anything at or above 2^49 ends in
   // the same byte as 2^49 in both lit modes, so it is held at 2^49 from here on.
   // ------------------------------------------------------------------
   logic [PRD_W-1:0] dif_prod [3];
   logic [P_W-1:0]   s5_p_in [3];
   logic [P_W-1:0]   s5_p_ff [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         dif_prod[c] = PRD_W'(s4_acc_ff[c]) * PRD_W'(diffuse_ff[c*CH_W +: CH_W]);
         s5_p_in[c]  = (|dif_prod[c][PRD_W-1:FRAC_W]) ? P_W'(1) << FRAC_W
                                                       : dif_prod[c][P_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         s5_p_ff <= s5_p_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 6: every channel brought to 49 fractional bits for the mode.
   // ------------------------------------------------------------------
   logic [V_W-1:0] s6_v_in [4];
   logic [V_W-1:0] s6_v_ff [4];
   chan_type       dif_a;

   assign dif_a = diffuse_ff[3*CH_W +: CH_W];

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         s6_v_in[c] = '0;
      end
      case (side_ff[5].mode)
         MODE_MATERIAL: begin
            for (int c = 0; c < 4; c++) begin
               s6_v_in[c] = V_W'(diffuse_ff[c*CH_W +: CH_W]) << ONE_SHIFT;
            end
         end
         MODE_VERTEX: begin
            for (int c = 0; c < 4; c++) begin
               s6_v_in[c] = V_W'(side_ff[5].vtx[c]) << ONE_SHIFT;
            end
         end
         MODE_LIT: begin
            for (int c = 0; c < 3; c++) begin
               s6_v_in[c] = V_W'(s5_p_ff[c]) << LIT_SHIFT;
            end
            s6_v_in[3] = V_W'(dif_a) << ONE_SHIFT;
         end
         MODE_LIT_VERTEX: begin
            for (int c = 0; c < 3; c++) begin
               s6_v_in[c] = V_W'(s5_p_ff[c]) * V_W'(side_ff[5].vtx[c]);
            end
            s6_v_in[3] = V_W'((2*CH_W)'(dif_a) * (2*CH_W)'(side_ff[5].vtx[3]))
                         << ALPHA_SHIFT;
         end
         default: begin
            for (int c = 0; c < 4; c++) begin
               s6_v_in[c] = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy[6]) begin
         s6_v_ff <= s6_v_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 7: clamp to one and scale by 255 with truncation, into the
   // output register. 255 * x is formed as 256 * x - x.
   // ------------------------------------------------------------------
   logic [FRAC_W+7:0] scaled [4];
   logic [7:0]        byte_val [4];
   logic [31:0]       rsp_color_in, rsp_color_ff;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         scaled[c]   = {s6_v_ff[c][FRAC_W-1:0], 8'h00} - (FRAC_W+8)'(s6_v_ff[c][FRAC_W-1:0]);
         byte_val[c] = (|s6_v_ff[c][V_W-1:FRAC_W]) ? 8'hFF : scaled[c][FRAC_W+7:FRAC_W];
      end
      rsp_color_in = {byte_val[3], byte_val[2], byte_val[1], byte_val[0]};
   end

   always_ff @(posedge clock) begin
      if (rdy[STAGES]) begin
         rsp_color_ff <= rsp_color_in;
      end
   end

   assign rsp_packed_color = rsp_color_ff;

`ifndef NO_ASSERTIONS
   // Reset empties the pipeline, so no result is offered after it.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   // An item in a stage whose successor cannot load must stay in place.
   for (genvar k = 1; k < STAGES; k++) begin : g_hold
      a_stage_hold: assert property (@(posedge clock) disable iff (reset)
         vld_ff[k] && !rdy[k+1] |=> vld_ff[k])
         else $error("item lost from a stalled pipeline stage");
   end

   // Occupancy grows by one for an item taken with nothing delivered.
   a_fill: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) && !(rsp_valid && rsp_ready) |=>
      $countones(vld_ff) == $past($countones(vld_ff)) + 1)
      else $error("pipeline occupancy did not grow by one item");

   // Occupancy shrinks by one for a result delivered with nothing taken.
   a_drain: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && req_ready) && (rsp_valid && rsp_ready) |=>
      $countones(vld_ff) == $past($countones(vld_ff)) - 1)
      else $error("pipeline occupancy did not shrink by one item");

   // A vertex alpha of one or more must saturate in vertex colour mode.
   a_alpha_sat: assert property (@(posedge clock) disable iff (reset)
      vld_ff[STAGES-1] && rdy[STAGES] && side_ff[STAGES-1].mode == MODE_VERTEX &&
      side_ff[STAGES-1].vtx[3] >= 10'd256 |=> rsp_packed_color[31:24] == 8'hFF)
      else $error("vertex alpha above one did not saturate");
`endif

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the per-vertex diffuse lighting pipeline.
`timescale 1ns / 1ps

// The testbench drives vertex items into the req_ channel and checks every packed colour
// that comes back on the rsp_ channel.
//
// A clocked driver takes items from a queue that the main initial block fills, one phase
// at a time. Its inputs change on the falling edge. A monitor samples both handshakes on
// the rising edge. When an item is accepted, the monitor rebuilds it from the ports and
// works out its colour with a predictor of its own. That colour joins a FIFO of expected
// colours, and each result must match the oldest entry.
//
// Both ends pause at random. Now and then they switch into a calm stretch with no pauses,
// so that bubbles land on every stage of the pipeline and back-pressure reaches the front.
// The lighting registers are read live by the pipeline, so they are only rewritten between
// phases. By then every expected colour has arrived and the pipeline has settled.
module tb
   import vlc_pkg::*;
();

   localparam int CLOCK_HALF = 4;
   localparam int LIGHT_NUM  = 6;
   // Fractional bits of the lit sum (Q2.8 colour times Q2.13 intensity times Q4.12 scale).
   localparam int SUM_FRAC   = 33;
   localparam int AMB_ALIGN  = SUM_FRAC - 8;
   // Index with no register behind it: writes there must be ignored.
   localparam logic [2:0] CFG_NONE = 3'd7;

   typedef enum int {
      SETUP_RANDOM,
      SETUP_ZERO,
      SETUP_FULL
   } setup_style_type;

   // Vertex channels: 0 blue, 1 green, 2 red, 3 alpha; intensities by light number.
   typedef struct packed {
      mode_type                          mode;
      logic [3:0][CH_W-1:0]              argb;
      logic [LIGHTS_MAX-1:0][INTEN_W-1:0] inten;
   } vertex_item_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_we = 1'b0;
   logic [2:0]          csr_index = '0;
   logic [CSR_W-1:0]    csr_wdata = '0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_mode = '0;
   logic [CH_W-1:0]     req_vertex_alpha = '0;
   logic [CH_W-1:0]     req_vertex_red = '0;
   logic [CH_W-1:0]     req_vertex_green = '0;
   logic [CH_W-1:0]     req_vertex_blue = '0;
   logic signed [INTEN_W-1:0] req_intensity_zero = '0;
   logic signed [INTEN_W-1:0] req_intensity_one = '0;
   logic signed [INTEN_W-1:0] req_intensity_two = '0;
   logic signed [INTEN_W-1:0] req_intensity_three = '0;
   logic signed [INTEN_W-1:0] req_intensity_four = '0;
   logic signed [INTEN_W-1:0] req_intensity_five = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [31:0]         rsp_packed_color;

   // Our own copy of the lighting registers, starting from their reset values.
   logic [CSR_W-1:0]    cfg_light_pair [3] = '{default: '0};
   logic [29:0]         cfg_ambient = '0;
   logic [39:0]         cfg_diffuse = '0;
   logic [SCALE_W-1:0]  cfg_scale = SCALE_RESET;
   logic [5:0]          cfg_enable = '0;

   vertex_item_type     vertex_queue [$];
   logic [31:0]         expected_colors [$];
   int                  queued_count = 0;
   int                  accepted_count = 0;
   int                  error_count = 0;
   logic                req_taken = 1'b0;
   logic                rsp_taken = 1'b0;
   int                  send_gap = 0;
   int                  stall_left = 0;
   logic                send_calm = 1'b0;
   logic                recv_calm = 1'b0;

   vertex_light_color_top #(
      .LIGHT_COUNT(LIGHT_NUM)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_vertex_alpha    (req_vertex_alpha),
      .req_vertex_red      (req_vertex_red),
      .req_vertex_green    (req_vertex_green),
      .req_vertex_blue     (req_vertex_blue),
      .req_intensity_zero  (req_intensity_zero),
      .req_intensity_one   (req_intensity_one),
      .req_intensity_two   (req_intensity_two),
      .req_intensity_three (req_intensity_three),
      .req_intensity_four  (req_intensity_four),
      .req_intensity_five  (req_intensity_five),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_packed_color    (rsp_packed_color)
   );

   always #CLOCK_HALF clock = ~clock;

   // A value with frac fractional bits becomes floor(255 * min(value, 1)). The vectors are
   // wide enough that no product in the lit path can overflow.
   function automatic logic [7:0] quantise(input logic [79:0] val, input int frac);
      logic [79:0] one;
      one = 80'd1 << frac;
      if (val >= one) return 8'hFF;
      return 8'((val * 80'd255) >> frac);
   endfunction

   // The packed ARGB colour that the pipeline should return for one vertex under the
   // current register settings.
   function automatic logic [31:0] shade_vertex(input vertex_item_type v);
      logic [79:0] acc [3];
      logic [79:0] sum;
      logic [7:0]  level [4];
      logic [29:0] lamp;
      longint      prod;
      int          c, i;
      case (v.mode)
         MODE_MATERIAL: begin
            // The diffuse material saturates per channel rather than wrapping.
            for (c = 0; c < 4; c++) level[c] = quantise(80'(cfg_diffuse[c*CH_W +: CH_W]), 8);
         end
         MODE_VERTEX: begin
            for (c = 0; c < 4; c++) level[c] = quantise(80'(v.argb[c]), 8);
         end
         default: begin
            for (c = 0; c < 3; c++) acc[c] = 80'(cfg_ambient[c*CH_W +: CH_W]) << AMB_ALIGN;
            for (i = 0; i < LIGHT_NUM; i++) begin
               if (cfg_enable[i]) begin
                  prod = longint'($signed(v.inten[i])) * longint'(cfg_scale);
                  // A light that faces away contributes nothing.
                  if (prod > 0) begin
                     lamp = cfg_light_pair[i/2][(i%2)*30 +: 30];
                     for (c = 0; c < 3; c++)
                        acc[c] += 80'(lamp[c*CH_W +: CH_W]) * 80'(prod);
                  end
               end
            end
            for (c = 0; c < 3; c++) begin
               sum = acc[c] * 80'(cfg_diffuse[c*CH_W +: CH_W]);
               if (v.mode == MODE_LIT_VERTEX)
                  level[c] = quantise(sum * 80'(v.argb[c]), SUM_FRAC + 16);
               else
                  level[c] = quantise(sum, SUM_FRAC + 8);
            end
            if (v.mode == MODE_LIT_VERTEX)
               level[3] = quantise(80'(cfg_diffuse[3*CH_W +: CH_W]) * 80'(v.argb[3]), 16);
            else
               level[3] = quantise(80'(cfg_diffuse[3*CH_W +: CH_W]), 8);
         end
      endcase
      return {level[3], level[2], level[1], level[0]};
   endfunction

   // Channel values bunched around zero, one and the top of the range, so that both
   // saturated and unsaturated results turn up often.
   function automatic logic [CH_W-1:0] rand_chan();
      case ($urandom_range(0, 5))
         0: return CH_W'($urandom_range(0, 1023));
         1: return CH_W'($urandom_range(0, 64));
         2: return CH_W'($urandom_range(200, 300));
         3: return $urandom_range(0, 1) ? 10'd256 : 10'd1023;
         4: return CH_W'($urandom_range(0, 2) * 511);
         default: return CH_W'($urandom_range(0, 256));
      endcase
   endfunction

   function automatic logic [INTEN_W-1:0] rand_inten();
      case ($urandom_range(0, 4))
         0: return INTEN_W'($urandom_range(0, 65535));
         1: return INTEN_W'($urandom_range(0, 2048));
         2: return INTEN_W'($urandom_range(32768, 65535));
         3: return INTEN_W'($urandom_range(0, 8192));
         default: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      endcase
   endfunction

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
   endtask

   // Register writes go out on a falling edge. Our copy keeps only each register's
   // width, as the hardware does.
   task automatic write_csr(input logic [2:0] index, input logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (index)
         CFG_LIGHT_PAIR_A: cfg_light_pair[0] = data;
         CFG_LIGHT_PAIR_B: cfg_light_pair[1] = data;
         CFG_LIGHT_PAIR_C: cfg_light_pair[2] = data;
         CFG_AMBIENT_RGB:  cfg_ambient = data[29:0];
         CFG_DIFFUSE_ARGB: cfg_diffuse = data[39:0];
         CFG_INTEN_SCALE:  cfg_scale = data[SCALE_W-1:0];
         CFG_LIGHT_ENABLE: cfg_enable = data[5:0];
         default: ;
      endcase
   endtask

   task automatic queue_vertex(input mode_type m, input logic [3:0][CH_W-1:0] argb,
                               input logic [LIGHTS_MAX-1:0][INTEN_W-1:0] inten);
      vertex_item_type v;
      v.mode  = m;
      v.argb  = argb;
      v.inten = inten;
      vertex_queue.push_back(v);
      queued_count++;
   endtask

   // Holds the sender back until every queued item has been taken and every colour has
   // come back. It then lets the pipeline settle.
   task automatic drain_pipeline();
      while (accepted_count != queued_count || expected_colors.size() != 0)
         @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic load_lighting(input setup_style_type style);
      logic [CSR_W-1:0] word;
      int r, k;
      for (r = CFG_LIGHT_PAIR_A; r <= CFG_LIGHT_ENABLE; r++) begin
         case (style)
            SETUP_ZERO: word = '0;
            SETUP_FULL: word = '1;
            default: begin
               // The upper bits are deliberately filled for the ambient and diffuse registers too.
               for (k = 0; k < 6; k++) word[k*CH_W +: CH_W] = rand_chan();
               if (r == CFG_INTEN_SCALE) begin
                  case ($urandom_range(0, 2))
                     0: word = CSR_W'(SCALE_RESET);
                     1: word = CSR_W'($urandom_range(0, 8192));
                     default: word = CSR_W'($urandom_range(0, 65535));
                  endcase
               end else if (r == CFG_LIGHT_ENABLE) begin
                  word = CSR_W'($urandom_range(0, 63));
               end
            end
         endcase
         write_csr(3'(r), word);
      end
   endtask

   // Driver: presents one item at a time. The payload holds steady until the item is
   // taken, and a random gap is drawn for each item.
   always @(negedge clock) begin : driver
      vertex_item_type next_vertex;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (vertex_queue.size() > 0) begin
            next_vertex = vertex_queue.pop_front();
            req_mode            <= next_vertex.mode;
            req_vertex_alpha    <= next_vertex.argb[3];
            req_vertex_red      <= next_vertex.argb[2];
            req_vertex_green    <= next_vertex.argb[1];
            req_vertex_blue     <= next_vertex.argb[0];
            req_intensity_zero  <= next_vertex.inten[0];
            req_intensity_one   <= next_vertex.inten[1];
            req_intensity_two   <= next_vertex.inten[2];
            req_intensity_three <= next_vertex.inten[3];
            req_intensity_four  <= next_vertex.inten[4];
            req_intensity_five  <= next_vertex.inten[5];
            req_valid <= 1'b1;
            if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
            send_gap = send_calm ? 0 : $urandom_range(0, 8);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: after each colour it takes, it may draw a random stall unless it is in a calm stretch.
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_taken) begin
            if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
            stall_left = recv_calm ? 0 : $urandom_range(0, 8);
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Monitor: results are checked before the new prediction is added. A colour that
   // arrives on the same edge as an item is taken can then never be matched against
   // that item's own prediction.
   always @(posedge clock) begin : monitor
      vertex_item_type seen;
      logic [31:0]     want;
      req_taken <= !reset && req_valid && req_ready;
      rsp_taken <= !reset && rsp_valid && rsp_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_colors.size() == 0) begin
               flag_error($sformatf("unexpected colour %08h", rsp_packed_color));
            end else begin
               want = expected_colors.pop_front();
               if (rsp_packed_color !== want)
                  flag_error($sformatf("colour mismatch: expected %08h, got %08h",
                                       want, rsp_packed_color));
            end
         end
         if (req_valid && req_ready) begin
            seen.mode  = mode_type'(req_mode);
            seen.argb  = {req_vertex_alpha, req_vertex_red, req_vertex_green, req_vertex_blue};
            seen.inten = {req_intensity_five, req_intensity_four, req_intensity_three,
                          req_intensity_two, req_intensity_one, req_intensity_zero};
            expected_colors.push_back(shade_vertex(seen));
            accepted_count++;
         end
      end
   end

   initial begin : stimulus
      int phase, n;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Registers at their reset values: black material, no lights, unit scale.
      queue_vertex(MODE_MATERIAL,   {4{10'd1023}}, {6{16'h7FFF}});
      queue_vertex(MODE_VERTEX,     {4{10'd1023}}, {6{16'h7FFF}});
      queue_vertex(MODE_LIT,        {4{10'd1023}}, {6{16'h7FFF}});
      queue_vertex(MODE_LIT_VERTEX, {4{10'd1023}}, {6{16'h7FFF}});
      drain_pipeline();

      // A hand-picked scene. The diffuse alpha and green are above one, so the material
      // mode must saturate them. The ambient write carries ones above its width, and a
      // write to the unused index must leave everything alone.
      write_csr(CFG_LIGHT_PAIR_A, {10'd1023, 10'd0, 10'd512, 10'd256, 10'd256, 10'd256});
      write_csr(CFG_LIGHT_PAIR_B, {10'd128, 10'd64, 10'd32, 10'd0, 10'd1023, 10'd0});
      write_csr(CFG_LIGHT_PAIR_C, {10'd1, 10'd2, 10'd3, 10'd1023, 10'd1023, 10'd1023});
      write_csr(CFG_AMBIENT_RGB,  {30'h3FFFFFFF, 10'd32, 10'd0, 10'd1023});
      write_csr(CFG_DIFFUSE_ARGB, CSR_W'({10'd300, 10'd256, 10'd1023, 10'd128}));
      write_csr(CFG_INTEN_SCALE,  CSR_W'(SCALE_RESET));
      write_csr(CFG_LIGHT_ENABLE, CSR_W'(6'b111111));
      write_csr(CFG_NONE, '1);
      queue_vertex(MODE_MATERIAL,   {4{10'd0}}, {6{16'h0000}});
      queue_vertex(MODE_VERTEX,     {4{10'd0}}, {6{16'h0000}});
      queue_vertex(MODE_VERTEX,     {4{10'd1023}}, {6{16'hFFFF}});
      queue_vertex(MODE_VERTEX,     {10'd256, 10'd255, 10'd257, 10'd1}, {6{16'h0000}});
      queue_vertex(MODE_LIT,        {4{10'd512}}, {6{16'h0000}});
      // Every light behind the surface: only the ambient term remains.
      queue_vertex(MODE_LIT,        {4{10'd512}}, {6{16'h8000}});
      queue_vertex(MODE_LIT,        {4{10'd512}}, {6{16'h7FFF}});
      queue_vertex(MODE_LIT,        {4{10'd0}}, {16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h2000});
      queue_vertex(MODE_LIT,        {4{10'd0}},
                   {16'h7FFF, 16'h4000, 16'hE000, 16'h0001, 16'hFFFF, 16'h1000});
      queue_vertex(MODE_LIT_VERTEX, {4{10'd256}},
                   {16'h0, 16'h0, 16'h2000, 16'h0, 16'h0, 16'h0});
      queue_vertex(MODE_LIT_VERTEX, {4{10'd0}}, {6{16'h7FFF}});
      queue_vertex(MODE_LIT_VERTEX, {4{10'd1023}}, {6{16'h7FFF}});
      queue_vertex(MODE_LIT_VERTEX, {10'd255, 10'd128, 10'd64, 10'd32}, {6{16'h0400}});
      drain_pipeline();

      // Largest scale with only the odd lights enabled.
      write_csr(CFG_INTEN_SCALE,  CSR_W'(16'hFFFF));
      write_csr(CFG_LIGHT_ENABLE, CSR_W'(6'b101010));
      write_csr(CFG_DIFFUSE_ARGB, CSR_W'({10'd256, 10'd200, 10'd100, 10'd50}));
      queue_vertex(MODE_LIT,        {4{10'd100}}, {6{16'h7FFF}});
      queue_vertex(MODE_LIT_VERTEX, {4{10'd100}}, {6{16'hFFFF}});
      queue_vertex(MODE_LIT,        {4{10'd100}}, {6{16'h0001}});
      queue_vertex(MODE_LIT_VERTEX, {10'd1, 10'd700, 10'd255, 10'd256}, {6{16'h2000}});
      drain_pipeline();

      // Random phases. The first sets every register to all ones and the second to all
      // zeros; the rest draw fresh lighting. The sender waits for the pipeline to empty
      // at the end of each phase.
      for (phase = 0; phase < 12; phase++) begin
         load_lighting(phase == 0 ? SETUP_FULL : phase == 1 ? SETUP_ZERO : SETUP_RANDOM);
         for (n = 0; n < 70; n++)
            queue_vertex(mode_type'($urandom_range(0, 3)),
                         {rand_chan(), rand_chan(), rand_chan(), rand_chan()},
                         {rand_inten(), rand_inten(), rand_inten(),
                          rand_inten(), rand_inten(), rand_inten()});
         drain_pipeline();
      end

      if (expected_colors.size() != 0)
         flag_error($sformatf("%0d colours never arrived", expected_colors.size()));
      if (error_count == 0) begin
         $display("vertex_light_color_top test passed");
      end else begin
         $display("vertex_light_color_top test failed");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin : watchdog
      #2_000_000;
      $display("vertex_light_color_top test failed");
      $finish;
   end

endmodule

@@ files.f @@
hdl/vlc_pkg.sv
hdl/vertex_light_color_top.sv
test/tb.sv
